FILE: hdl/ssort_pkg.sv
// shared constants and control/status types of the selection sorter
package ssort_pkg;

    localparam int DEPTH   = 64;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    // commands from the controller to the datapath
    typedef struct packed {
        logic store;       // write the accepted item into the element memory if it has room
        logic scan_start;  // begin a minimum scan at the current output position
        logic scan_run;    // advance the minimum scan by one memory read
        logic emit;        // load the found minimum into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done;   // every stored entry from the output position on was compared
        logic set_end;     // current output position is the last one of the set
        logic out_free;    // output register can take an item this cycle
    } t_status;

endpackage

FILE: hdl/ssort_in_if.sv
// input channel of the selection sorter: one value per item plus a last flag
interface ssort_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ssort_pkg::DATA_W-1:0] value;
    logic                                last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

FILE: hdl/ssort_out_if.sv
// output channel of the selection sorter: one sorted value per item
interface ssort_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ssort_pkg::DATA_W-1:0] sorted_value;
    logic                                end_of_set;
    logic                                overflow;

    modport source (output valid, output sorted_value, output end_of_set, output overflow,
                    input ready);
    modport sink (input valid, input sorted_value, input end_of_set, input overflow,
                  output ready);
endinterface

FILE: hdl/ssort_ctrl.sv
// controller state machine of the selection sorter
module ssort_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  ssort_pkg::t_status i_status,
    output ssort_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_COLLECT = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_EMIT    = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_COLLECT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_in_last) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.set_end) begin
                        n_state = S_COLLECT;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

endmodule

FILE: hdl/ssort_dp.sv
// datapath of the selection sorter: element memory, minimum scan, output register
module ssort_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ssort_pkg::t_cmd                     i_cmd,
    output ssort_pkg::t_status                  o_status,
    input  logic signed [ssort_pkg::DATA_W-1:0] i_value,
    ssort_out_if.source                         o_out
);

    logic signed [ssort_pkg::DATA_W-1:0]  r_mem [ssort_pkg::DEPTH];

    logic [ssort_pkg::COUNT_W-1:0]        r_count;
    logic                                 r_ovf;
    logic [ssort_pkg::COUNT_W-1:0]        r_pos;
    logic [ssort_pkg::COUNT_W-1:0]        r_j;
    logic                                 r_pend;
    logic                                 r_have;
    logic [ssort_pkg::ADDR_W-1:0]         r_rd_idx;
    logic signed [ssort_pkg::DATA_W-1:0]  r_rdata;
    logic signed [ssort_pkg::DATA_W-1:0]  r_min;
    logic [ssort_pkg::ADDR_W-1:0]         r_min_idx;
    logic signed [ssort_pkg::DATA_W-1:0]  r_first;
    logic                                 r_out_valid;
    logic signed [ssort_pkg::DATA_W-1:0]  r_out_value;
    logic                                 r_out_end;
    logic                                 r_out_ovf;

    logic                                 w_room;
    logic                                 w_issue;
    logic                                 w_take_min;
    logic                                 w_set_end;
    logic [ssort_pkg::COUNT_W-1:0]        w_pos_next;

    assign w_room     = r_count < ssort_pkg::COUNT_W'(ssort_pkg::DEPTH);
    assign w_issue    = i_cmd.scan_run && (r_j < r_count);
    assign w_take_min = r_pend && (!r_have || (r_rdata < r_min));
    assign w_set_end  = (r_pos + ssort_pkg::COUNT_W'(1)) == r_count;
    assign w_pos_next = w_set_end ? '0 : r_pos + ssort_pkg::COUNT_W'(1);

    assign o_status.scan_done = (r_j == r_count) && !r_pend;
    assign o_status.set_end   = w_set_end;
    assign o_status.out_free  = !r_out_valid || o_out.ready;

    // element memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && w_room) begin
            r_mem[r_count[ssort_pkg::ADDR_W-1:0]] <= i_value;
        end else if (i_cmd.emit) begin
            // swap half: the displaced first entry moves into the minimum's slot
            r_mem[r_min_idx] <= r_first;
        end
        if (w_issue) begin
            r_rdata <= r_mem[r_j[ssort_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_pos       <= '0;
            r_j         <= '0;
            r_pend      <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                if (w_room) begin
                    r_count <= r_count + ssort_pkg::COUNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_pos <= w_pos_next;
                if (w_set_end) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end
            if (i_cmd.scan_start) begin
                r_j    <= i_cmd.emit ? w_pos_next : r_pos;
                r_pend <= 1'b0;
                r_have <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_pend <= w_issue;
                if (w_issue) begin
                    r_j <= r_j + ssort_pkg::COUNT_W'(1);
                end
                if (r_pend) begin
                    r_have <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_idx <= r_j[ssort_pkg::ADDR_W-1:0];
        end
        if (w_take_min) begin
            r_min     <= r_rdata;
            r_min_idx <= r_rd_idx;
        end
        // first read of a scan is the entry at the output position
        if (r_pend && !r_have) begin
            r_first <= r_rdata;
        end
        if (i_cmd.emit) begin
            r_out_value <= r_min;
            r_out_end   <= w_set_end;
            r_out_ovf   <= w_set_end & r_ovf;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.end_of_set   = r_out_end;
    assign o_out.overflow     = r_out_ovf;

endmodule

FILE: hdl/selection_sorter_unit.sv
// top level of the selection sorter: controller, datapath and checks
//
//  channel  | dir | payload                              | accepted when
//  ---------+-----+--------------------------------------+-------------------
//  i_in     | in  | value (s32), last                    | valid && ready
//  o_out    | out | sorted_value (s32), end_of_set, ovf  | valid && ready
//
// a set is collected first, then sorted and emitted one output position at a time:
//   each position takes one memory read per remaining entry, as the memory has a
//   single read port, then waits for the last compare and the scan-done status, then emits
// synchronous active-low reset clears counts, flags and the controller state
// input ready is low from the last item until the final result is loaded
// a stalled output holds the sort at the emit step, nothing is lost
module selection_sorter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssort_in_if.sink    i_in,
    ssort_out_if.source o_out
);

    ssort_pkg::t_cmd    w_cmd;
    ssort_pkg::t_status w_status;

    // sequencing: collect, scan for the minimum, emit, repeat
    ssort_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // storage, compare and output register
    ssort_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_value  (i_in.value),
        .o_out    (o_out)
    );

    // collection and scanning never overlap
    a_store_vs_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.store && w_cmd.scan_run))
        else $error("store during minimum scan");

    // an emit never overwrites a result that is still waiting
    a_emit_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.out_free)
        else $error("emit into a busy output register");

    // after the final result of a set the block takes input again
    a_back_to_collect : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_status.set_end) |=> i_in.ready)
        else $error("no return to collecting after the final result");

    // overflow only rides on the final result of a set
    a_ovf_final : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.end_of_set) |-> !o_out.overflow)
        else $error("overflow flag on a non-final result");

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the selection sorter: random sets, stalls and overflow
module tb_top;

    typedef struct {
        logic signed [ssort_pkg::DATA_W-1:0] value;
        logic                                last;
        bit                                  after_drain;  // hold this item until all sorted items are out
    } t_set_item;

    typedef struct {
        logic signed [ssort_pkg::DATA_W-1:0] sorted_value;
        logic                                end_of_set;
        logic                                overflow;
    } t_sorted_item;

    localparam int HOLD_CYCLES = 400;

    logic i_clk;
    logic i_rst_n;

    ssort_in_if  in_ch ();
    ssort_out_if out_ch ();

    selection_sorter_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 i_clk = ~i_clk;

    t_set_item    unsent_items [$];
    t_sorted_item sorted_expect [$];

    // shadow of the set being collected
    logic signed [ssort_pkg::DATA_W-1:0] set_values [ssort_pkg::DEPTH];
    int                                  set_count;
    logic                                set_dropped;

    int n_total;
    int n_offered;
    int n_accepted;
    int n_errors;
    int hold_left;
    bit hold_done;

    // stores one value and, on the last one, queues the whole set in ascending order
    task automatic collect_and_sort(input logic signed [ssort_pkg::DATA_W-1:0] v,
                                    input logic is_last);
        logic signed [ssort_pkg::DATA_W-1:0] tmp;
        int                                  lo;
        t_sorted_item                        res;
        if (set_count < ssort_pkg::DEPTH) begin
            set_values[set_count] = v;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (is_last) begin
            for (int i = 0; i + 1 < set_count; i++) begin
                lo = i;
                for (int j = i + 1; j < set_count; j++) begin
                    if (set_values[j] < set_values[lo]) lo = j;
                end
                tmp            = set_values[i];
                set_values[i]  = set_values[lo];
                set_values[lo] = tmp;
            end
            for (int k = 0; k < set_count; k++) begin
                res.sorted_value = set_values[k];
                res.end_of_set   = (k + 1 == set_count);
                res.overflow     = (k + 1 == set_count) ? set_dropped : 1'b0;
                sorted_expect.push_back(res);
            end
            set_count   = 0;
            set_dropped = 1'b0;
        end
    endtask

    // idle rate in percent: receiver lazy first, then sender lazy, then nobody idles
    function automatic int idle_pct(input bit receiver);
        if (n_offered < n_total / 3) return receiver ? 82 : 24;
        if (n_offered < 2 * n_total / 3) return receiver ? 24 : 82;
        return 0;
    endfunction

    // mix of full-range, near-zero (lots of duplicates) and corner values
    function automatic logic signed [ssort_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom_range(8) - 4;
            1: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(input logic signed [ssort_pkg::DATA_W-1:0] v, input logic is_last,
                            input bit drain);
        t_set_item item;
        item.value       = v;
        item.last        = is_last;
        item.after_drain = drain;
        unsent_items.push_back(item);
    endtask

    // sender: holds an offered item until taken, then maybe idles
    always @(posedge i_clk) begin : drive_in
        t_set_item item;
        logic      offer;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                collect_and_sort(in_ch.value, in_ch.last);
                n_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                offer = 1'b0;
                if (unsent_items.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                    if (!unsent_items[0].after_drain || sorted_expect.size() == 0) begin
                        item = unsent_items.pop_front();
                        in_ch.value <= item.value;
                        in_ch.last  <= item.last;
                        offer = 1'b1;
                        n_offered++;
                    end
                end
                in_ch.valid <= offer;
            end
        end
    end

    // receiver: random stalls plus one long hold-off once a result is waiting
    always @(posedge i_clk) begin : drive_out_ready
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (!hold_done && out_ch.valid && n_offered >= 2 * n_total / 3 + 10) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= idle_pct(1'b1));
            end
        end
    end

    // compare every taken result with the oldest expected one
    always @(posedge i_clk) begin : check_out
        t_sorted_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (sorted_expect.size() == 0) begin
                $error("unexpected sorted item: sorted_value %0d", out_ch.sorted_value);
                n_errors++;
            end else begin
                want = sorted_expect.pop_front();
                if (out_ch.sorted_value !== want.sorted_value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.sorted_value, out_ch.sorted_value);
                    n_errors++;
                end
                if (out_ch.end_of_set !== want.end_of_set) begin
                    $error("end_of_set: expected %0b, got %0b",
                           want.end_of_set, out_ch.end_of_set);
                    n_errors++;
                end
                if (out_ch.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, out_ch.overflow);
                    n_errors++;
                end
            end
        end
    end

    initial begin : stimulus
        int size;
        int pick;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        in_ch.last   = 1'b0;
        out_ch.ready = 1'b0;
        set_count    = 0;
        set_dropped  = 1'b0;
        n_offered    = 0;
        n_accepted   = 0;
        n_errors     = 0;
        hold_left    = 0;
        hold_done    = 1'b0;

        // single-value sets at zero and both extremes
        add_item('0, 1'b1, 1'b0);
        add_item(32'sh8000_0000, 1'b1, 1'b0);
        add_item(32'sh7fff_ffff, 1'b1, 1'b0);
        // extremes, alternating bit patterns and duplicates in one set
        add_item(32'sh7fff_ffff, 1'b0, 1'b1);
        add_item(32'sh8000_0000, 1'b0, 1'b0);
        add_item(-1, 1'b0, 1'b0);
        add_item('0, 1'b0, 1'b0);
        add_item(1, 1'b0, 1'b0);
        add_item(32'sh5555_5555, 1'b0, 1'b0);
        add_item(32'shaaaa_aaaa, 1'b0, 1'b0);
        add_item(7, 1'b0, 1'b0);
        add_item(7, 1'b0, 1'b0);
        add_item(-1, 1'b0, 1'b0);
        add_item(32'sh8000_0000, 1'b1, 1'b0);
        // already ascending, then strictly descending
        add_item(1, 1'b0, 1'b0);
        add_item(2, 1'b0, 1'b0);
        add_item(3, 1'b1, 1'b0);
        add_item(9, 1'b0, 1'b0);
        add_item(8, 1'b0, 1'b0);
        add_item(-9, 1'b1, 1'b0);

        // random sets: mostly short, some medium, some one short of full, full, and overflowing
        while (unsent_items.size() < 430) begin
            pick = $urandom_range(99);
            if (pick < 55)      size = $urandom_range(8, 1);
            else if (pick < 80) size = $urandom_range(40, 9);
            else if (pick < 86) size = ssort_pkg::DEPTH - 1;
            else if (pick < 93) size = ssort_pkg::DEPTH;
            else                size = $urandom_range(ssort_pkg::DEPTH + 8,
                                                      ssort_pkg::DEPTH + 1);
            for (int k = 0; k < size; k++) begin
                add_item(rand_value(), k + 1 == size, k == 0 && $urandom_range(5) == 0);
            end
        end
        n_total = unsent_items.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_total || sorted_expect.size() != 0) @(posedge i_clk);
        repeat (4 * ssort_pkg::DEPTH) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #800000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
hdl/ssort_pkg.sv
hdl/ssort_in_if.sv
hdl/ssort_out_if.sv
hdl/ssort_ctrl.sv
hdl/ssort_dp.sv
hdl/selection_sorter_unit.sv
tb/tb_top.sv
